// File: rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg: shared definitions of the bright-spot centroid block
// Sizes, gray weights, register indexes, the frame totals record and the
// states of the result sequencer.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Frame size limits.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Field and counter widths.
    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = $clog2(MAX_WIDTH) + 1;
    localparam int HGT_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int HALF_W     = DIM_W - 1;
    localparam int LX_W       = $clog2(MAX_WIDTH / 2);
    localparam int COUNT_W    = 22;
    localparam int XSUM_W     = 32;
    localparam int YSUM_W     = 33;
    localparam int DEN_W      = COUNT_W + HGT_W;
    localparam int REM_W      = DEN_W;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = $clog2(FRAC_W);

    // BT.601 gray weights, 14-bit fixed point with rounding.
    localparam int GRAY_SUM_W = 22;
    localparam int GRAY_SHIFT = 14;
    localparam int COEF_B     = 1868;
    localparam int COEF_G     = 9617;
    localparam int COEF_R     = 4899;
    localparam int GRAY_ROUND = 8192;

    // Register reset values.
    localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(250);
    localparam logic [DIM_W-1:0] WIDTH_RESET     = DIM_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RESET    = HGT_W'(480);

    // Queue of finished frame totals between accumulator and divider.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } cfg_reg_t;

    // Totals of one finished frame, both halves, with the spans to divide by.
    typedef struct packed {
        logic [1:0][COUNT_W-1:0] count;
        logic [1:0][XSUM_W-1:0]  x_sum;
        logic [1:0][YSUM_W-1:0]  y_sum;
        logic [HALF_W-1:0]       half;
        logic [HGT_W-1:0]        height;
    } frame_totals_t;

    // Result sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_PREP,
        BK_DIV,
        BK_LOAD
    } back_state_t;

endpackage

// File: rtl/bsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_front: pixel intake and per-half accumulation
// Stage one converts to gray, mirrors the column and classifies the pixel;
// stage two thresholds it, updates the half sums and hands frame totals on.
// ----------------------------------------------------------------------------
module bsc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  logic [bsc_pkg::PIX_W-1:0]     blue,
    input  logic [bsc_pkg::PIX_W-1:0]     green,
    input  logic [bsc_pkg::PIX_W-1:0]     red,
    input  logic                          frame_start,
    input  logic [bsc_pkg::PIX_W-1:0]     threshold,
    input  logic [bsc_pkg::DIM_W-1:0]     frame_width,
    input  logic [bsc_pkg::HGT_W-1:0]     frame_height,
    input  logic [bsc_pkg::QCNT_W-1:0]    q_count,
    output logic                          push,
    output bsc_pkg::frame_totals_t        push_data
);
    import bsc_pkg::*;

    typedef struct packed {
        logic              start;
        logic              counted;
        logic              side;
        logic [LX_W-1:0]   lx;
        logic [ROW_W-1:0]  row;
        logic [PIX_W-1:0]  gray;
        logic              frame_end;
    } pix_class_t;

    logic                  pix_accept;
    logic [DIM_W-1:0]      w_eff;
    logic [HGT_W-1:0]      h_eff;
    logic [HALF_W-1:0]     half;
    logic [COL_W-1:0]      col_cur;
    logic [ROW_W-1:0]      row_cur;
    logic [DIM_W-1:0]      x_mir;
    logic                  in_range;
    logic                  line_end;
    logic                  frame_end;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic                  bright;

    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  s1_valid_reg, s1_valid_next;
    pix_class_t            s1_reg, s1_next;
    logic [COUNT_W-1:0]    cnt_reg [2];
    logic [COUNT_W-1:0]    cnt_next [2];
    logic [XSUM_W-1:0]     xs_reg [2];
    logic [XSUM_W-1:0]     xs_next [2];
    logic [YSUM_W-1:0]     ys_reg [2];
    logic [YSUM_W-1:0]     ys_next [2];
    logic [COUNT_W-1:0]    cnt_new [2];
    logic [XSUM_W-1:0]     xs_new [2];
    logic [YSUM_W-1:0]     ys_new [2];

    // Room is kept in the queue for a frame end already in stage one.
    assign pix_ready  = ({1'b0, q_count} + (QCNT_W + 1)'(s1_valid_reg && s1_reg.frame_end))
                        < (QCNT_W + 1)'(QDEPTH);
    assign pix_accept = pix_valid && pix_ready;

    // Effective frame size, clamped to the supported range.
    always_comb
    begin
        if (frame_width < DIM_W'(2))
            w_eff = DIM_W'(2);
        else if (frame_width > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = frame_width;

        if (frame_height < HGT_W'(1))
            h_eff = HGT_W'(1);
        else if (frame_height > HGT_W'(MAX_HEIGHT))
            h_eff = HGT_W'(MAX_HEIGHT);
        else
            h_eff = frame_height;

        half = w_eff[DIM_W-1:1];
    end

    // Position of the incoming pixel; a frame start restarts the counters.
    assign col_cur   = frame_start ? '0 : col_reg;
    assign row_cur   = frame_start ? '0 : row_reg;
    assign in_range  = (DIM_W'(col_cur) < w_eff) && (HGT_W'(row_cur) < h_eff);
    assign x_mir     = w_eff - DIM_W'(1) - DIM_W'(col_cur);
    assign line_end  = DIM_W'(col_cur) >= (w_eff - DIM_W'(1));
    assign frame_end = line_end && (HGT_W'(row_cur) >= (h_eff - HGT_W'(1)));

    // Gray level with rounding.
    assign gray_sum = GRAY_SUM_W'(blue) * GRAY_SUM_W'(COEF_B)
                    + GRAY_SUM_W'(green) * GRAY_SUM_W'(COEF_G)
                    + GRAY_SUM_W'(red) * GRAY_SUM_W'(COEF_R)
                    + GRAY_SUM_W'(GRAY_ROUND);

    // Stage one: classify the accepted pixel and advance the counters.
    always_comb
    begin
        s1_next       = s1_reg;
        s1_valid_next = pix_accept;
        col_next      = col_reg;
        row_next      = row_reg;
        if (pix_accept)
        begin
            s1_next.start     = frame_start;
            s1_next.gray      = gray_sum[GRAY_SHIFT +: PIX_W];
            s1_next.row       = row_cur;
            s1_next.frame_end = frame_end;
            if (x_mir < DIM_W'(half))
            begin
                s1_next.counted = in_range;
                s1_next.side    = 1'b0;
                s1_next.lx      = LX_W'(x_mir);
            end
            else if (x_mir < {half, 1'b0})
            begin
                s1_next.counted = in_range;
                s1_next.side    = 1'b1;
                s1_next.lx      = LX_W'(x_mir - DIM_W'(half));
            end
            else
            begin
                s1_next.counted = 1'b0;
                s1_next.side    = 1'b0;
                s1_next.lx      = '0;
            end

            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (line_end)
            begin
                col_next = '0;
                row_next = row_cur + ROW_W'(1);
            end
            else
            begin
                col_next = col_cur + COL_W'(1);
                row_next = row_cur;
            end
        end
    end

    // Stage two: threshold and accumulate; a frame end hands the totals on.
    assign bright = s1_reg.counted && (s1_reg.gray > threshold);

    always_comb
    begin
        push             = s1_valid_reg && s1_reg.frame_end;
        push_data.half   = half;
        push_data.height = h_eff;
        for (int h = 0; h < 2; h++)
        begin
            if (bright && (s1_reg.side == 1'(h)))
            begin
                cnt_new[h] = (s1_reg.start ? '0 : cnt_reg[h]) + COUNT_W'(1);
                xs_new[h]  = (s1_reg.start ? '0 : xs_reg[h]) + XSUM_W'(s1_reg.lx);
                ys_new[h]  = (s1_reg.start ? '0 : ys_reg[h]) + YSUM_W'(s1_reg.row);
            end
            else
            begin
                cnt_new[h] = s1_reg.start ? '0 : cnt_reg[h];
                xs_new[h]  = s1_reg.start ? '0 : xs_reg[h];
                ys_new[h]  = s1_reg.start ? '0 : ys_reg[h];
            end
            push_data.count[h] = cnt_new[h];
            push_data.x_sum[h] = xs_new[h];
            push_data.y_sum[h] = ys_new[h];

            if (!s1_valid_reg)
            begin
                cnt_next[h] = cnt_reg[h];
                xs_next[h]  = xs_reg[h];
                ys_next[h]  = ys_reg[h];
            end
            else if (s1_reg.frame_end)
            begin
                cnt_next[h] = '0;
                xs_next[h]  = '0;
                ys_next[h]  = '0;
            end
            else
            begin
                cnt_next[h] = cnt_new[h];
                xs_next[h]  = xs_new[h];
                ys_next[h]  = ys_new[h];
            end
        end
    end

    // Control state and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            for (int h = 0; h < 2; h++)
            begin
                cnt_reg[h] <= '0;
                xs_reg[h]  <= '0;
                ys_reg[h]  <= '0;
            end
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            for (int h = 0; h < 2; h++)
            begin
                cnt_reg[h] <= cnt_next[h];
                xs_reg[h]  <= xs_next[h];
                ys_reg[h]  <= ys_next[h];
            end
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

endmodule

// File: rtl/bsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_queue: short queue of frame totals
// Decouples pixel accumulation from the end-of-frame division so that each
// side may stall on its own.
// ----------------------------------------------------------------------------
module bsc_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  bsc_pkg::frame_totals_t      push_data,
    input  logic                        pop,
    output bsc_pkg::frame_totals_t      head,
    output logic [bsc_pkg::QCNT_W-1:0]  count
);
    import bsc_pkg::*;

    frame_totals_t     mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Pointers wrap naturally; the depth is a power of two.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/bsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_back: centroid division and result output
// For each half it forms the two denominators, runs two restoring dividers
// one quotient bit a cycle and places the result in the output register.
// ----------------------------------------------------------------------------
module bsc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsc_pkg::frame_totals_t      head,
    input  logic                        q_valid,
    output logic                        pop,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic                        res_side,
    output logic                        res_found,
    output logic [bsc_pkg::FRAC_W-1:0]  res_x_fraction,
    output logic [bsc_pkg::FRAC_W-1:0]  res_y_fraction
);
    import bsc_pkg::*;

    back_state_t        state_reg, state_next;
    logic               side_reg, side_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DEN_W-1:0]   den_x_reg, den_x_next;
    logic [DEN_W-1:0]   den_y_reg, den_y_next;
    logic [REM_W-1:0]   rem_x_reg, rem_x_next;
    logic [REM_W-1:0]   rem_y_reg, rem_y_next;
    logic [FRAC_W-1:0]  q_x_reg, q_x_next;
    logic [FRAC_W-1:0]  q_y_reg, q_y_next;
    logic               sat_x_reg, sat_x_next;
    logic               sat_y_reg, sat_y_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_side_reg, out_side_next;
    logic               out_found_reg, out_found_next;
    logic [FRAC_W-1:0]  out_xf_reg, out_xf_next;
    logic [FRAC_W-1:0]  out_yf_reg, out_yf_next;

    logic [COUNT_W-1:0] cur_count;
    logic [XSUM_W-1:0]  cur_xs;
    logic [YSUM_W-1:0]  cur_ys;
    logic               cur_found;
    logic [REM_W:0]     rem_x_sh;
    logic [REM_W:0]     rem_y_sh;
    logic               bit_x;
    logic               bit_y;

    // Totals of the half in progress.
    assign cur_count = head.count[side_reg];
    assign cur_xs    = head.x_sum[side_reg];
    assign cur_ys    = head.y_sum[side_reg];
    assign cur_found = cur_count != '0;

    // One restoring division step for each fraction.
    assign rem_x_sh = {rem_x_reg, 1'b0};
    assign rem_y_sh = {rem_y_reg, 1'b0};
    assign bit_x    = rem_x_sh >= {1'b0, den_x_reg};
    assign bit_y    = rem_y_sh >= {1'b0, den_y_reg};

    // Sequencer: multiply, divide, then load the output register.
    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        step_next      = step_reg;
        den_x_next     = den_x_reg;
        den_y_next     = den_y_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        q_x_next       = q_x_reg;
        q_y_next       = q_y_reg;
        sat_x_next     = sat_x_reg;
        sat_y_next     = sat_y_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_side_next  = out_side_reg;
        out_found_next = out_found_reg;
        out_xf_next    = out_xf_reg;
        out_yf_next    = out_yf_reg;
        pop            = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                side_next = 1'b0;
                if (q_valid)
                    state_next = BK_MUL;
            end
            BK_MUL:
            begin
                den_x_next = DEN_W'(cur_count) * DEN_W'(head.half);
                den_y_next = DEN_W'(cur_count) * DEN_W'(head.height);
                state_next = BK_PREP;
            end
            BK_PREP:
            begin
                // A sum not below its denominator gives a quotient of one or more.
                rem_x_next = REM_W'(cur_xs);
                rem_y_next = REM_W'(cur_ys);
                sat_x_next = REM_W'(cur_xs) >= den_x_reg;
                sat_y_next = REM_W'(cur_ys) >= den_y_reg;
                q_x_next   = '0;
                q_y_next   = '0;
                step_next  = '0;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                rem_x_next = bit_x ? REM_W'(rem_x_sh - {1'b0, den_x_reg}) : REM_W'(rem_x_sh);
                rem_y_next = bit_y ? REM_W'(rem_y_sh - {1'b0, den_y_reg}) : REM_W'(rem_y_sh);
                q_x_next   = {q_x_reg[FRAC_W-2:0], bit_x};
                q_y_next   = {q_y_reg[FRAC_W-2:0], bit_y};
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(FRAC_W - 1))
                    state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next = 1'b1;
                    out_side_next  = side_reg;
                    out_found_next = cur_found;
                    if (!cur_found)
                    begin
                        out_xf_next = '0;
                        out_yf_next = '0;
                    end
                    else
                    begin
                        out_xf_next = sat_x_reg ? '1 : q_x_reg;
                        out_yf_next = sat_y_reg ? '1 : q_y_reg;
                    end
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        state_next = BK_MUL;
                    end
                    else
                    begin
                        pop        = 1'b1;
                        side_next  = 1'b0;
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign res_valid      = out_valid_reg;
    assign res_side       = out_side_reg;
    assign res_found      = out_found_reg;
    assign res_x_fraction = out_xf_reg;
    assign res_y_fraction = out_yf_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            side_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge clk)
    begin
        den_x_reg     <= den_x_next;
        den_y_reg     <= den_y_next;
        rem_x_reg     <= rem_x_next;
        rem_y_reg     <= rem_y_next;
        q_x_reg       <= q_x_next;
        q_y_reg       <= q_y_next;
        sat_x_reg     <= sat_x_next;
        sat_y_reg     <= sat_y_next;
        out_side_reg  <= out_side_next;
        out_found_reg <= out_found_next;
        out_xf_reg    <= out_xf_next;
        out_yf_reg    <= out_yf_next;
    end

endmodule

// File: rtl/bright_spot_centroid_halves.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bright_spot_centroid_halves: bright-spot centroid of each mirrored half
// Thresholds the gray level of a BGR pixel stream and reports, per frame, the
// normalised centroid of the bright pixels in the left and then right half.
//
//   channel  direction  contents
//   s_axis   in         pixel: tdata blue/green/red, tuser frame_start
//   m_axis   out        result: tdata x/y fraction, tuser side/found, tlast
//   cfg      in         register write: index and data, always ready
//
// One pixel is taken every cycle unless input stalls; two pipeline stages
// classify and add it. At frame end the totals enter a two-entry queue; after
// an idle state picks up its head, the divider multiplies, sets up, forms the
// 16-bit fractions and loads the result, for each half. The load waits while
// the output register holds an untaken result. Pixel input stalls when the
// queue holds two frames not yet divided, or one and a frame end is in stage one.
// Reset is asynchronous and restores the register defaults and clears sums.
// ----------------------------------------------------------------------------
module bright_spot_centroid_halves (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [3*bsc_pkg::PIX_W-1:0]        s_axis_tdata,  // blue, green, red
    input  logic [0:0]                         s_axis_tuser,  // frame_start
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [2*bsc_pkg::FRAC_W-1:0]       m_axis_tdata,  // x_fraction, y_fraction
    output logic [1:0]                         m_axis_tuser,  // side, found
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bsc_pkg::*;

    logic [PIX_W-1:0]   threshold_reg, threshold_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [HGT_W-1:0]   height_reg, height_next;

    logic               q_push;
    logic               q_pop;
    frame_totals_t      q_push_data;
    frame_totals_t      q_head;
    logic [QCNT_W-1:0]  q_count;
    logic               res_side;
    logic               res_found;
    logic [FRAC_W-1:0]  res_x_fraction;
    logic [FRAC_W-1:0]  res_y_fraction;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        threshold_next = threshold_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_next = cfg_data[PIX_W-1:0];
                REG_FRAME_WIDTH:  width_next     = cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_next    = cfg_data[HGT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    // Pixel intake and accumulation.
    bsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (s_axis_tvalid),
        .pix_ready    (s_axis_tready),
        .blue         (s_axis_tdata[PIX_W-1:0]),
        .green        (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .red          (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
        .frame_start  (s_axis_tuser[0]),
        .threshold    (threshold_reg),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .q_count      (q_count),
        .push         (q_push),
        .push_data    (q_push_data)
    );

    // Frame totals queue.
    bsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .count     (q_count)
    );

    // Division and result output.
    bsc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .q_valid        (q_count != '0),
        .pop            (q_pop),
        .res_valid      (m_axis_tvalid),
        .res_ready      (m_axis_tready),
        .res_side       (res_side),
        .res_found      (res_found),
        .res_x_fraction (res_x_fraction),
        .res_y_fraction (res_y_fraction)
    );

    assign m_axis_tdata = {res_y_fraction, res_x_fraction};
    assign m_axis_tuser = {res_found, res_side};
    assign m_axis_tlast = res_side;

`ifndef SYNTHESIS
    // The right-half result, and only it, closes the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]))
        else $error("tlast does not match the result side");

    // An empty half reports zero fractions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata == '0))
        else $error("fractions not zero for an empty half");

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("totals queue overflow");

    // A full queue holds back the pixel stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == QCNT_W'(QDEPTH)) |-> !s_axis_tready)
        else $error("pixel request taken with the totals queue full");
`endif

endmodule
